### sv/ewmq_pkg.sv
// ---------------------------------------------------------------------------
// ewmq_pkg
// shared constants and controller/datapath command and status types
// ---------------------------------------------------------------------------
package ewmq_pkg;

  localparam int EVENT_DEPTH = 16;
  localparam int WAIT_DEPTH  = 16;
  localparam int ID_BITS     = 16;

  localparam int EV_IDX_W = $clog2(EVENT_DEPTH);
  localparam int WT_IDX_W = $clog2(WAIT_DEPTH);
  localparam int EV_CNT_W = $clog2(EVENT_DEPTH + 1);
  localparam int WT_CNT_W = $clog2(WAIT_DEPTH + 1);

  localparam int SCAN_W = (EV_CNT_W > WT_CNT_W) ? EV_CNT_W : WT_CNT_W;

  localparam logic       FUNC_POST  = 1'b0;
  localparam logic       FUNC_WAIT  = 1'b1;
  localparam logic [1:0] KIND_LOAD  = 2'd0;

  typedef enum logic [1:0] {
    ST_MATCHED   = 2'd0,
    ST_EV_QUEUED = 2'd1,
    ST_WT_QUEUED = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture input beat
    logic scan_clr;    // reset scan index
    logic scan_inc;    // advance scan index
    logic hit_take;    // deliver matched entry into result
    logic shift;       // close gap: move entry idx+1 to idx
    logic remove_done; // decrement count of scanned queue
    logic append;      // append captured item to its queue
    logic drop;        // result = dropped
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic func;
    logic scan_end;   // index reached count
    logic hit;        // entry at index matches
    logic shift_end;  // idx+1 >= count
    logic full;       // own queue full
  } sts_t;

endpackage

### sv/ewmq_ctrl.sv
// ---------------------------------------------------------------------------
// ewmq_ctrl
// sequencer: scan, remove-with-shift, append or drop, then one result strobe
// ---------------------------------------------------------------------------
module ewmq_ctrl import ewmq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output logic out_valid,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic   valid_nxt, valid_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load_in  = 1'b1;
          ctl.scan_clr = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.full) ctl.drop = 1'b1;
          else          ctl.append = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.hit) begin
          ctl.hit_take = 1'b1;
          state_nxt    = S_SHIFT;
        end else begin
          ctl.scan_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          ctl.remove_done = 1'b1;
          valid_nxt       = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          ctl.shift    = 1'b1;
          ctl.scan_inc = 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

### sv/ewmq_dp.sv
// ---------------------------------------------------------------------------
// ewmq_dp
// queue storage, scan index, match compare and result registers
// ---------------------------------------------------------------------------
module ewmq_dp import ewmq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  output sts_t                sts,
  input  logic                in_func,
  input  logic [ID_BITS-1:0]  in_event_id,
  input  logic [1:0]          in_event_kind,
  input  logic [31:0]         in_event_offset,
  input  logic [31:0]         in_event_length,
  input  logic                in_accept_any,
  input  logic [ID_BITS-1:0]  in_filter_id,
  input  logic [15:0]         in_waiter_tag,
  output logic [1:0]          out_status,
  output logic [15:0]         out_done_tag,
  output logic [1:0]          out_done_kind,
  output logic [ID_BITS-1:0]  out_done_id,
  output logic [31:0]         out_done_offset,
  output logic [31:0]         out_done_length
);

  logic [ID_BITS-1:0] ev_ids_r     [EVENT_DEPTH];
  logic [1:0]         ev_kinds_r   [EVENT_DEPTH];
  logic [31:0]        ev_offsets_r [EVENT_DEPTH];
  logic [31:0]        ev_lengths_r [EVENT_DEPTH];
  logic               wt_any_r     [WAIT_DEPTH];
  logic [ID_BITS-1:0] wt_filters_r [WAIT_DEPTH];
  logic [15:0]        wt_tags_r    [WAIT_DEPTH];
  logic [EV_CNT_W-1:0] ev_count_r;
  logic [WT_CNT_W-1:0] wt_count_r;

  logic               func_r;
  logic [ID_BITS-1:0] id_r, filter_r;
  logic [1:0]         kind_r;
  logic [31:0]        off_r, len_r;
  logic               any_r;
  logic [15:0]        tag_r;
  logic [SCAN_W-1:0]  idx_r;

  logic [EV_IDX_W-1:0] ev_i, ev_i1;
  logic [WT_IDX_W-1:0] wt_i, wt_i1;
  logic [SCAN_W-1:0]   idx1;
  logic [SCAN_W-1:0]   cnt;

  assign ev_i  = idx_r[EV_IDX_W-1:0];
  assign wt_i  = idx_r[WT_IDX_W-1:0];
  assign idx1  = idx_r + SCAN_W'(1);
  assign ev_i1 = idx1[EV_IDX_W-1:0];
  assign wt_i1 = idx1[WT_IDX_W-1:0];
  assign cnt   = (func_r == FUNC_POST) ? SCAN_W'(wt_count_r) : SCAN_W'(ev_count_r);

  always_comb begin
    sts.func      = func_r;
    sts.scan_end  = (idx_r >= cnt);
    sts.shift_end = (idx1 >= cnt);
    if (func_r == FUNC_POST) begin
      sts.hit  = wt_any_r[wt_i] || (wt_filters_r[wt_i] == id_r);
      sts.full = (ev_count_r == EV_CNT_W'(EVENT_DEPTH));
    end else begin
      sts.hit  = any_r || (filter_r == ev_ids_r[ev_i]);
      sts.full = (wt_count_r == WT_CNT_W'(WAIT_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_count_r <= '0;
      wt_count_r <= '0;
    end else if (ctl.remove_done) begin
      if (func_r == FUNC_POST) wt_count_r <= wt_count_r - WT_CNT_W'(1);
      else                     ev_count_r <= ev_count_r - EV_CNT_W'(1);
    end else if (ctl.append) begin
      if (func_r == FUNC_POST) ev_count_r <= ev_count_r + EV_CNT_W'(1);
      else                     wt_count_r <= wt_count_r + WT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      func_r   <= in_func;
      id_r     <= in_event_id;
      kind_r   <= in_event_kind;
      off_r    <= in_event_offset;
      len_r    <= in_event_length;
      any_r    <= in_accept_any;
      filter_r <= in_filter_id;
      tag_r    <= in_waiter_tag;
    end
    if (ctl.scan_clr)      idx_r <= '0;
    else if (ctl.scan_inc) idx_r <= idx1;

    if (ctl.shift) begin
      if (func_r == FUNC_POST) begin
        wt_any_r[wt_i]     <= wt_any_r[wt_i1];
        wt_filters_r[wt_i] <= wt_filters_r[wt_i1];
        wt_tags_r[wt_i]    <= wt_tags_r[wt_i1];
      end else begin
        ev_ids_r[ev_i]     <= ev_ids_r[ev_i1];
        ev_kinds_r[ev_i]   <= ev_kinds_r[ev_i1];
        ev_offsets_r[ev_i] <= ev_offsets_r[ev_i1];
        ev_lengths_r[ev_i] <= ev_lengths_r[ev_i1];
      end
    end
    if (ctl.append) begin
      if (func_r == FUNC_POST) begin
        ev_ids_r[ev_count_r[EV_IDX_W-1:0]]     <= id_r;
        ev_kinds_r[ev_count_r[EV_IDX_W-1:0]]   <= kind_r;
        ev_offsets_r[ev_count_r[EV_IDX_W-1:0]] <= off_r;
        ev_lengths_r[ev_count_r[EV_IDX_W-1:0]] <= len_r;
      end else begin
        wt_any_r[wt_count_r[WT_IDX_W-1:0]]     <= any_r;
        wt_filters_r[wt_count_r[WT_IDX_W-1:0]] <= filter_r;
        wt_tags_r[wt_count_r[WT_IDX_W-1:0]]    <= tag_r;
      end
    end

    // result register
    if (ctl.hit_take) begin
      out_status <= ST_MATCHED;
      if (func_r == FUNC_POST) begin
        out_done_tag    <= wt_tags_r[wt_i];
        out_done_kind   <= kind_r;
        out_done_id     <= id_r;
        out_done_offset <= (kind_r == KIND_LOAD) ? off_r : '0;
        out_done_length <= (kind_r == KIND_LOAD) ? len_r : '0;
      end else begin
        out_done_tag    <= tag_r;
        out_done_kind   <= ev_kinds_r[ev_i];
        out_done_id     <= ev_ids_r[ev_i];
        out_done_offset <= (ev_kinds_r[ev_i] == KIND_LOAD) ? ev_offsets_r[ev_i] : '0;
        out_done_length <= (ev_kinds_r[ev_i] == KIND_LOAD) ? ev_lengths_r[ev_i] : '0;
      end
    end else if (ctl.append || ctl.drop) begin
      if (ctl.drop)                 out_status <= ST_DROPPED;
      else if (func_r == FUNC_POST) out_status <= ST_EV_QUEUED;
      else                          out_status <= ST_WT_QUEUED;
      out_done_tag    <= '0;
      out_done_kind   <= '0;
      out_done_id     <= '0;
      out_done_offset <= '0;
      out_done_length <= '0;
    end
  end

endmodule

### sv/event_wait_matching_queues.sv
// ---------------------------------------------------------------------------
// event_wait_matching_queues
// rendezvous engine pairing posted events with waiters, wildcard id match
// ---------------------------------------------------------------------------
// Usage: drive the in_ fields and raise start while busy is low; the beat is
// taken at that edge. in_func = 0 posts an event, 1 submits a wait. Each
// beat yields exactly one result, shown on the out_ ports for one cycle with
// out_valid high; the receiver cannot stall and must take it.
// Sequence: the beat is captured, queued entries are scanned in order one
// per cycle, then on a match the following entries are shifted down one per
// cycle to close the gap, then the registered result is shown in the closing
// state. The 16-entry register-file queues are scanned and shifted a single
// entry per cycle. busy is low only when idle.
// Reset (rst_n low, synchronous) empties both queues and drops any beat in
// flight; entry storage itself is not cleared.
// ---------------------------------------------------------------------------
module event_wait_matching_queues import ewmq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [ID_BITS-1:0]  in_event_id,
  input  logic [1:0]          in_event_kind,
  input  logic [31:0]         in_event_offset,
  input  logic [31:0]         in_event_length,
  input  logic                in_accept_any,
  input  logic [ID_BITS-1:0]  in_filter_id,
  input  logic [15:0]         in_waiter_tag,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [15:0]         out_done_tag,
  output logic [1:0]          out_done_kind,
  output logic [ID_BITS-1:0]  out_done_id,
  output logic [31:0]         out_done_offset,
  output logic [31:0]         out_done_length
);

  ctl_t ctl;
  sts_t sts;

  ewmq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .sts(sts), .ctl(ctl)
  );

  ewmq_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_func(in_func), .in_event_id(in_event_id), .in_event_kind(in_event_kind),
    .in_event_offset(in_event_offset), .in_event_length(in_event_length),
    .in_accept_any(in_accept_any), .in_filter_id(in_filter_id),
    .in_waiter_tag(in_waiter_tag), .out_status(out_status),
    .out_done_tag(out_done_tag), .out_done_kind(out_done_kind),
    .out_done_id(out_done_id), .out_done_offset(out_done_offset),
    .out_done_length(out_done_length)
  );

  // result strobe only while a beat is being finished
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside a busy item");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("two result strobes in a row");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not start work");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_MATCHED) |-> (out_done_tag == '0 && out_done_id == '0))
    else $error("unmatched result carries payload");

endmodule

### bench/event_wait_matching_queues_tb.sv
// ---------------------------------------------------------------------------
// event_wait_matching_queues_tb
// self-checking bench for the event/waiter rendezvous engine: directed
// corner beats, then random post/wait traffic with id reuse, wildcards and
// queue-full drops, checked against an in-bench queue model
// ---------------------------------------------------------------------------
module event_wait_matching_queues_tb;
  import ewmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [1:0]  kind;
    logic [15:0] id;
    logic [31:0] offset;
    logic [31:0] length;
  } outcome_t;

  int errors = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  class rendezvous_sb;
    logic [15:0] ev_id[$];
    logic [1:0]  ev_kind[$];
    logic [31:0] ev_off[$];
    logic [31:0] ev_len[$];
    logic        wt_any[$];
    logic [15:0] wt_filter[$];
    logic [15:0] wt_tag[$];
    outcome_t    pending[$];
    int matched = 0, drops = 0, checked = 0;

    function void deliver(logic [15:0] tag, logic [1:0] kind, logic [15:0] id,
                          logic [31:0] off, logic [31:0] len);
      outcome_t o;
      o.status = ST_MATCHED; o.tag = tag; o.kind = kind; o.id = id;
      o.offset = (kind == KIND_LOAD) ? off : 32'd0;
      o.length = (kind == KIND_LOAD) ? len : 32'd0;
      pending.push_back(o);
      matched++;
    endfunction

    function void note_beat(logic func, logic [15:0] id, logic [1:0] kind,
                            logic [31:0] off, logic [31:0] len, logic any,
                            logic [15:0] filter, logic [15:0] tag);
      outcome_t o;
      o = '{default: '0};
      if (func == FUNC_POST) begin
        foreach (wt_any[i]) begin
          if (wt_any[i] || wt_filter[i] == id) begin
            deliver(wt_tag[i], kind, id, off, len);
            wt_any.delete(i); wt_filter.delete(i); wt_tag.delete(i);
            return;
          end
        end
        if (ev_id.size() >= EVENT_DEPTH) begin
          o.status = ST_DROPPED; drops++;
        end else begin
          ev_id.push_back(id); ev_kind.push_back(kind);
          ev_off.push_back(off); ev_len.push_back(len);
          o.status = ST_EV_QUEUED;
        end
      end else begin
        foreach (ev_id[i]) begin
          if (any || filter == ev_id[i]) begin
            deliver(tag, ev_kind[i], ev_id[i], ev_off[i], ev_len[i]);
            ev_id.delete(i); ev_kind.delete(i); ev_off.delete(i); ev_len.delete(i);
            return;
          end
        end
        if (wt_any.size() >= WAIT_DEPTH) begin
          o.status = ST_DROPPED; drops++;
        end else begin
          wt_any.push_back(any); wt_filter.push_back(filter); wt_tag.push_back(tag);
          o.status = ST_WT_QUEUED;
        end
      end
      pending.push_back(o);
    endfunction

    task check_result(outcome_t r);
      outcome_t w;
      if (pending.size() == 0) begin
        report("unexpected result", 32'(r.status), 32'd0);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (r.status !== w.status) report("status", 32'(r.status), 32'(w.status));
      if (r.tag !== w.tag) report("done_tag", 32'(r.tag), 32'(w.tag));
      if (r.kind !== w.kind) report("done_kind", 32'(r.kind), 32'(w.kind));
      if (r.id !== w.id) report("done_id", 32'(r.id), 32'(w.id));
      if (r.offset !== w.offset) report("done_offset", r.offset, w.offset);
      if (r.length !== w.length) report("done_length", r.length, w.length);
    endtask
  endclass

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid;
  logic        in_func = 0, in_accept_any = 0;
  logic [15:0] in_event_id = 0, in_filter_id = 0, in_waiter_tag = 0;
  logic [1:0]  in_event_kind = 0;
  logic [31:0] in_event_offset = 0, in_event_length = 0;
  logic [1:0]  out_status, out_done_kind;
  logic [15:0] out_done_tag, out_done_id;
  logic [31:0] out_done_offset, out_done_length;

  rendezvous_sb sb = new();
  int cycles = 0;
  bit quiet = 0;
  localparam int CYCLE_LIMIT = 200000;

  always #5 clk = ~clk;

  event_wait_matching_queues u_top (.*);

  always @(posedge clk) begin
    outcome_t r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && out_valid) begin
      r.status = out_status; r.tag = out_done_tag; r.kind = out_done_kind;
      r.id = out_done_id; r.offset = out_done_offset; r.length = out_done_length;
      sb.check_result(r);
    end
  end

  // one beat: drive at an edge, hold until taken with busy low
  // start stays high into the next beat unless that beat idles first
  task automatic send(logic func, logic [15:0] id, logic [1:0] kind,
                      logic [31:0] off, logic [31:0] len, logic any,
                      logic [15:0] filter, logic [15:0] tag);
    while (!quiet && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_func <= func; in_event_id <= id; in_event_kind <= kind;
    in_event_offset <= off; in_event_length <= len; in_accept_any <= any;
    in_filter_id <= filter; in_waiter_tag <= tag; start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_beat(func, id, kind, off, len, any, filter, tag);
  endtask

  task automatic post(logic [15:0] id, logic [1:0] kind, logic [31:0] off,
                      logic [31:0] len);
    send(FUNC_POST, id, kind, off, len, 1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_on(logic any, logic [15:0] filter, logic [15:0] tag);
    send(FUNC_WAIT, 16'($urandom), 2'($urandom), $urandom, $urandom, any, filter, tag);
  endtask

  initial begin
    int pool_sel;
    logic [15:0] id;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, all kinds, wildcard, full queues
    post(16'hFFFF, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_on(1'b0, 16'hFFFF, 16'hFFFF);
    post(16'h0000, 2'd3, 32'hDEAD_BEEF, 32'h1234_5678);
    wait_on(1'b1, 16'h0001, 16'h0000);
    wait_on(1'b0, 16'h0005, 16'hAAAA);
    post(16'h0005, 2'd1, 32'h1, 32'h2);
    for (int i = 0; i < 17; i++) post(16'(i), 2'(i), $urandom, $urandom);
    for (int i = 0; i < 17; i++) wait_on(1'b0, 16'(100 + i), 16'(i));
    wait_on(1'b1, 16'h0, 16'h5555);

    // random: small id pool so matches are common, with drift in queue depth
    for (int n = 0; n < 650; n++) begin
      quiet = (n >= 300 && n < 380);
      pool_sel = $urandom_range(9);
      id = (pool_sel < 8) ? 16'($urandom_range(7)) : 16'($urandom);
      if ($urandom_range(1) == 0)
        post(id, 2'($urandom), $urandom, $urandom);
      else
        wait_on($urandom_range(9) == 0, id, 16'($urandom));
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("checked %0d results: %0d matches, %0d drops", sb.checked, sb.matched,
             sb.drops);
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### sim.f
sv/ewmq_pkg.sv
sv/ewmq_ctrl.sv
sv/ewmq_dp.sv
sv/event_wait_matching_queues.sv
bench/event_wait_matching_queues_tb.sv
